// ----- sv/aes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte functions for the AES-128 round pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic   valid;
        block_t state;
        block_t round_key;
        logic [7:0] rcon;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        gf_double = a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

endpackage

// ----- sv/aes_round_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round cell
// One registered round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey,
// together with one key schedule step. Hands its result to the next cell.
// ----------------------------------------------------------------------------
module aes_round_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             last_round,
    input  aes_pkg::stage_t  prev,
    output aes_pkg::stage_t  curr
);

    aes_pkg::block_t shifted;
    aes_pkg::block_t mixed;
    aes_pkg::block_t key_next;
    aes_pkg::stage_t stage_reg;
    aes_pkg::stage_t stage_next;

    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, all;
        logic [31:0] t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                shifted[127 - 8 * (4 * c + r) -: 8] =
                    aes_pkg::SBOX[aes_pkg::get_byte(prev.state, 4 * ((c + r) % 4) + r)];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = shifted[127 - 32 * c -: 8];
            a1 = shifted[119 - 32 * c -: 8];
            a2 = shifted[111 - 32 * c -: 8];
            a3 = shifted[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32 * c -: 8] = a0 ^ all ^ aes_pkg::gf_double(a0 ^ a1);
            mixed[119 - 32 * c -: 8] = a1 ^ all ^ aes_pkg::gf_double(a1 ^ a2);
            mixed[111 - 32 * c -: 8] = a2 ^ all ^ aes_pkg::gf_double(a2 ^ a3);
            mixed[103 - 32 * c -: 8] = a3 ^ all ^ aes_pkg::gf_double(a3 ^ a0);
        end
        t = {aes_pkg::SBOX[prev.round_key[23:16]] ^ prev.rcon,
             aes_pkg::SBOX[prev.round_key[15:8]],
             aes_pkg::SBOX[prev.round_key[7:0]],
             aes_pkg::SBOX[prev.round_key[31:24]]};
        key_next[127:96] = prev.round_key[127:96] ^ t;
        key_next[95:64]  = prev.round_key[95:64] ^ key_next[127:96];
        key_next[63:32]  = prev.round_key[63:32] ^ key_next[95:64];
        key_next[31:0]   = prev.round_key[31:0] ^ key_next[63:32];

        stage_next.valid     = prev.valid;
        stage_next.round_key = key_next;
        stage_next.rcon      = aes_pkg::gf_double(prev.rcon);
        stage_next.state     = (last_round ? shifted : mixed) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign curr = stage_reg;

endmodule

// ----- sv/aes128_block_encrypt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Fully unrolled AES-128 encryption pipeline with a key register pair.
// ----------------------------------------------------------------------------
// The block accepts one plaintext beat per cycle unless the output stalls,
// and each beat passes one register for the initial AddRoundKey and one
// round cell per round, ten in a row, each carrying its own round key. The
// whole row advances together whenever the output register is empty or being
// taken, so a stall at the output holds every stage. Key writes must be made
// while the pipeline is empty.
module aes128_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] plaintext_high,
    input  logic [63:0] plaintext_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] ciphertext_high,
    output logic [63:0] ciphertext_low
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic advance;
    aes_pkg::stage_t init_reg;
    aes_pkg::stage_t chain [aes_pkg::NUM_ROUNDS + 1];

    assign cfg_ready = 1'b1;
    assign advance   = !chain[aes_pkg::NUM_ROUNDS].valid || out_ready;
    assign in_ready  = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
        end
        else if (advance)
        begin
            init_reg.valid     <= in_valid;
            init_reg.state     <= {plaintext_high, plaintext_low}
                                  ^ {key_high_reg, key_low_reg};
            init_reg.round_key <= {key_high_reg, key_low_reg};
            init_reg.rcon      <= aes_pkg::RCON_FIRST;
        end
    end

    assign chain[0] = init_reg;

    for (genvar g = 0; g < aes_pkg::NUM_ROUNDS; g++)
    begin : g_round
        aes_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .last_round (g == aes_pkg::NUM_ROUNDS - 1),
            .prev       (chain[g]),
            .curr       (chain[g + 1])
        );
    end

    assign out_valid       = chain[aes_pkg::NUM_ROUNDS].valid;
    assign ciphertext_high = chain[aes_pkg::NUM_ROUNDS].state[127:64];
    assign ciphertext_low  = chain[aes_pkg::NUM_ROUNDS].state[63:0];

`ifndef SYNTHESIS
    // A stalled result must not be overwritten by the pipeline.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ciphertext_high))
        else $error("stalled ciphertext changed");
    // An accepted beat is held in the entry register in the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> init_reg.valid)
        else $error("accepted beat lost at pipeline entry");
    // Input is refused only while a result waits at the output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output stall");
`endif

endmodule
